// ----- rtl/assert_macros.svh -----
// Assertion helpers for the ring buffer RTL.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/bwrb_pkg.sv -----
package bwrb_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 7;

    // Request type codes
    localparam logic [1:0] REQ_HDR  = 2'd0;
    localparam logic [1:0] REQ_DATA = 2'd1;
    localparam logic [1:0] REQ_GET  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_PUT_OK    = 2'd0;
    localparam logic [1:0] ST_PUT_REJ   = 2'd1;
    localparam logic [1:0] ST_GET_WORD  = 2'd2;
    localparam logic [1:0] ST_GET_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CNT_W-1:0]  block_count;
        logic [WORD_W-1:0] put_word;
        logic [CNT_W-1:0]  get_max;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] word_out;
        logic              last_word;
        logic [CNT_W-1:0]  occupancy;
        logic              full_res;
    } t_res;

endpackage

// ----- rtl/bwrb_ram.sv -----
module bwrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/block_word_ring_buffer.sv -----
// Block word ring buffer. A request is taken when start is high and busy is low.
// A header request answers with one result in the cycle after it is taken and
// never raises busy; a data word is taken every cycle busy is low and gives no
// result. A get of n words raises busy and streams them one per cycle, the first
// after the get state is entered and its read returns, since every word passes
// through the single registered read port of the word storage. A get on an empty
// ring gives one result in the next cycle. Results appear for exactly one
// cycle under o_res_strobe; the receiver cannot stall them and must capture
// each one. The capacity register is written only while the block is idle and
// empties the ring.
`include "assert_macros.svh"

module block_word_ring_buffer
    import bwrb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_res_strobe,
    output t_res             o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // One-hot sequencer: idle, or stepping the read pointer through a get run.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_GET  = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cap,   n_cap;
    logic [AW-1:0]    r_read,  n_read;
    logic [AW-1:0]    r_wr,    n_wr;
    logic [CNT_W-1:0] r_held,  n_held;
    logic [CNT_W-1:0] r_pend,  n_pend;
    logic             r_drop,  n_drop;
    logic [CNT_W-1:0] r_left,  n_left;
    logic             r_res_vld, n_res_vld;
    logic [1:0]       r_status, n_status;
    logic             r_last,  n_last;
    logic [CNT_W-1:0] r_occ,   n_occ;
    logic             r_full,  n_full;

    logic             acc;
    logic             cfg_wr;
    logic [CNT_W-1:0] cap;
    logic [CNT_W:0]   fit_sum;
    logic [CNT_W-1:0] added;
    logic [CNT_W-1:0] read_ext;
    logic [CNT_W-1:0] tail_sum, tail_1, tail;
    logic [CNT_W-1:0] wr_inc;
    logic [AW-1:0]    wr_next;
    logic [CNT_W-1:0] run, n_1, n_run;
    logic [CNT_W-1:0] rd_inc;
    logic [CNT_W-1:0] held_dec;
    logic             ram_we;
    logic [WORD_W-1:0] ram_q;

    // Clamp capacity into 1..DEPTH.
    always_comb begin
        if (r_cap == '0) begin
            cap = CNT_W'(1);
        end else if (r_cap > DEPTH_C) begin
            cap = DEPTH_C;
        end else begin
            cap = r_cap;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign acc         = start && (r_state == S_IDLE);
    // Hold off a register write while a request is offered in the same cycle.
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Header fit check and write tail.
    assign fit_sum  = {1'b0, r_held} + {1'b0, i_req.block_count};
    assign added    = r_held + i_req.block_count;
    assign read_ext = CNT_W'(r_read);
    assign tail_sum = read_ext + r_held;
    assign tail_1   = (tail_sum >= cap) ? tail_sum - cap : tail_sum;
    assign tail     = (tail_1 >= cap) ? '0 : tail_1;

    // Write pointer advance with wrap at capacity.
    assign wr_inc  = CNT_W'(r_wr) + CNT_W'(1);
    assign wr_next = (wr_inc >= cap) ? '0 : AW'(wr_inc);

    // Run length: contiguous up to the capacity wrap point, capped by get_max and
    // by the words held.
    assign run   = (read_ext < cap) ? cap - read_ext : '0;
    assign n_1   = (run > i_req.get_max) ? i_req.get_max : run;
    assign n_run = (n_1 > r_held) ? r_held : n_1;

    assign rd_inc   = read_ext + CNT_W'(1);
    assign held_dec = r_held - CNT_W'(1);

    assign ram_we = acc && (i_req.req_type == REQ_DATA) && (r_pend != '0) && !r_drop;

    bwrb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr),
        .i_wdata (i_req.put_word),
        .i_raddr (r_read),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state   = r_state;
        n_cap     = r_cap;
        n_read    = r_read;
        n_wr      = r_wr;
        n_held    = r_held;
        n_pend    = r_pend;
        n_drop    = r_drop;
        n_left    = r_left;
        n_res_vld = 1'b0;
        n_status  = r_status;
        n_last    = 1'b0;
        n_occ     = r_occ;
        n_full    = r_full;

        if (cfg_wr) begin
            // New capacity empties the ring.
            n_cap  = i_cfg_data;
            n_read = '0;
            n_wr   = '0;
            n_held = '0;
            n_pend = '0;
            n_drop = 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        case (i_req.req_type)
                            REQ_HDR: begin
                                n_pend    = '0;
                                n_drop    = 1'b0;
                                n_res_vld = 1'b1;
                                if (fit_sum > {1'b0, cap}) begin
                                    // Reject: drop the whole block.
                                    n_pend   = i_req.block_count;
                                    n_drop   = 1'b1;
                                    n_status = ST_PUT_REJ;
                                    n_occ    = r_held;
                                    n_full   = (r_held == cap);
                                end else begin
                                    // Reserve the block's space at the tail.
                                    n_wr     = AW'(tail);
                                    n_held   = added;
                                    n_pend   = i_req.block_count;
                                    n_status = ST_PUT_OK;
                                    n_occ    = added;
                                    n_full   = (added == cap);
                                end
                            end
                            REQ_DATA: begin
                                if (r_pend != '0) begin
                                    n_pend = r_pend - CNT_W'(1);
                                    if (!r_drop) begin
                                        n_wr = wr_next;
                                    end
                                    if (r_pend == CNT_W'(1)) begin
                                        n_drop = 1'b0;
                                    end
                                end
                            end
                            REQ_GET: begin
                                // Abandon any pending block.
                                n_pend = '0;
                                n_drop = 1'b0;
                                if (r_held == '0) begin
                                    n_res_vld = 1'b1;
                                    n_status  = ST_GET_EMPTY;
                                    n_occ     = r_held;
                                    n_full    = (r_held == cap);
                                end else if (n_run != '0) begin
                                    n_left  = n_run;
                                    n_state = S_GET;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_GET: begin
                    // Issue one read per cycle; the word leaves next cycle.
                    n_res_vld = 1'b1;
                    n_status  = ST_GET_WORD;
                    n_last    = (r_left == CNT_W'(1));
                    n_held    = held_dec;
                    n_occ     = held_dec;
                    n_full    = (held_dec == cap);
                    n_left    = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_read  = (rd_inc >= cap) ? '0 : AW'(rd_inc);
                        n_state = S_IDLE;
                    end else begin
                        n_read = AW'(rd_inc);
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= CNT_W'(64);
            r_read    <= '0;
            r_wr      <= '0;
            r_held    <= '0;
            r_pend    <= '0;
            r_drop    <= 1'b0;
            r_left    <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap     <= n_cap;
            r_read    <= n_read;
            r_wr      <= n_wr;
            r_held    <= n_held;
            r_pend    <= n_pend;
            r_drop    <= n_drop;
            r_left    <= n_left;
            r_res_vld <= n_res_vld;
        end
    end

    // Result fields need no reset; the strobe qualifies them.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_last   <= n_last;
        r_occ    <= n_occ;
        r_full   <= n_full;
    end

    assign o_res_strobe       = r_res_vld;
    assign o_res.status       = r_status;
    assign o_res.word_out     = (r_status == ST_GET_WORD) ? ram_q : '0;
    assign o_res.last_word    = r_last;
    assign o_res.occupancy    = r_occ;
    assign o_res.full_res     = r_full;

    // Reserved plus held words never exceed the effective capacity.
    `ASSERT_ALWAYS(a_held_cap, i_clk, i_rst_n, r_held <= cap)
    // A get run in progress always has words left to issue.
    `ASSERT_ALWAYS(a_run_left, i_clk, i_rst_n, (r_state != S_GET) || (r_left != '0))
    // Dropping only while words of a rejected block remain.
    `ASSERT_ALWAYS(a_drop_pend, i_clk, i_rst_n, !r_drop || (r_pend != '0))
    // A capacity write leaves an empty ring and no result.
    `ASSERT_NEXT(a_cfg_clear, i_clk, i_rst_n, cfg_wr, (r_held == '0) && !r_res_vld && (r_pend == '0))

endmodule
